// ===== design/pli_pkg.sv =====
// ============================================================================
// pli_pkg
// Shared widths, codes and structs for the piecewise-linear table lookup.
// ============================================================================
package pli_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = 9;

    // field formats
    localparam int E_W           = 24;
    localparam int XS_W          = 32;
    localparam int HF_W          = 17;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = XS_W + E_W;
    localparam int QCNT_W        = $clog2(XS_W + 1);

    // stream word widths
    localparam int IN_TDATA_W    = 88;
    localparam int OUT_TDATA_W   = 56;

    // constant one half in the fraction format
    localparam logic [HF_W-1:0] HF_HALF = HF_W'(1 << (FRACTION_BITS - 1));

    // item kinds on the input tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 9;
    localparam logic [CFG_AW-1:0] CFG_ENTRIES    = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_HF_PRESENT = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INTERP   = 2'd0,
        ST_CLAMP_LO = 2'd1,
        ST_CLAMP_HI = 2'd2
    } t_clamp;

    // one table entry as stored in memory
    typedef struct packed {
        logic [HF_W-1:0] hf;
        logic [XS_W-1:0] xs;
        logic [E_W-1:0]  energy;
    } t_entry;

    // one result word, cross section in the low bits
    typedef struct packed {
        t_clamp          clamp;
        logic [HF_W-1:0] hf;
        logic [XS_W-1:0] xs;
    } t_result;

    localparam int RES_W = $bits(t_result);

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [E_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [XS_W-1:0] quot;
        logic            rem_nz;
    } t_div_rsp;

endpackage

// ===== design/piecewise_linear_table_interp.sv =====
// ============================================================================
// piecewise_linear_table_interp
// Breakpoint table with linear interpolation of cross section and fraction.
// ============================================================================
// Input stream (s_*): tuser is the item kind, write or query. A write loads
// one breakpoint (energy, cross section, hydrogen fraction) into its slot;
// writes can follow back to back. A query searches the first entries_in_use
// breakpoints (at least two, at most the table depth) and returns one word on
// the output stream (m_*). A key at or below the first entry clamps to it and
// one at or above the last clamps to that; otherwise the scan finds the first
// breakpoint above the key. The table memory is read one entry a cycle during
// the scan, and each interpolated value takes one multiply and a bit-serial
// divide. One query is worked on at a time; s_tready is low while it runs and
// rises as the word enters the output register. The output register holds a
// finished word while the receiver stalls, and the next item can be accepted
// meanwhile. Reset sets entries_in_use to 2 and disables the fraction; table
// contents are not cleared and must be written before they are searched.
// ============================================================================
module piecewise_linear_table_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pli_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [pli_pkg::CFG_DW-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[7:0], energy_key[31:8], entry_cross_section[63:32],
    // entry_h_fraction[80:64], zero fill[87:81]
    input  logic [pli_pkg::IN_TDATA_W-1:0]      s_tdata,
    // opcode[0]
    input  logic                                s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cross_section_out[31:0], h_fraction_out[48:32], clamp_status[50:49],
    // zero fill[55:51]
    output logic [pli_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic [pli_pkg::CNT_W-1:0]      r_entries_in_use;
    logic                           r_hf_present;
    logic                           r_m_valid;
    pli_pkg::t_result               r_m_data;

    pli_pkg::t_entry                w_entry;
    pli_pkg::t_result               w_res;
    logic                           w_res_valid;
    logic                           w_res_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= pli_pkg::CNT_W'(2);
            r_hf_present     <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == pli_pkg::CFG_ENTRIES) begin
                r_entries_in_use <= i_cfg_wdata[pli_pkg::CNT_W-1:0];
            end
            if (i_cfg_addr == pli_pkg::CFG_HF_PRESENT) begin
                r_hf_present <= i_cfg_wdata[0];
            end
        end
    end

    // unpack the input word
    assign w_entry.energy = s_tdata[31:8];
    assign w_entry.xs     = s_tdata[63:32];
    assign w_entry.hf     = s_tdata[80:64];

    pli_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .o_s_tready       (s_tready),
        .i_opcode         (s_tuser),
        .i_entry_index    (s_tdata[pli_pkg::ADDR_W-1:0]),
        .i_entry          (w_entry),
        .i_entries_in_use (r_entries_in_use),
        .i_hf_present     (r_hf_present),
        .o_res_valid      (w_res_valid),
        .i_res_ready      (w_res_ready),
        .o_res            (w_res)
    );

    // output register
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
            r_m_data  <= w_res;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(pli_pkg::OUT_TDATA_W - pli_pkg::RES_W){1'b0}}, r_m_data};

endmodule

// ===== design/pli_ram.sv =====
// ============================================================================
// pli_ram
// Breakpoint table: one write port, one read port with registered data.
// ============================================================================
module pli_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [pli_pkg::ADDR_W-1:0]  i_waddr,
    input  pli_pkg::t_entry             i_wdata,
    input  logic [pli_pkg::ADDR_W-1:0]  i_raddr,
    output pli_pkg::t_entry             o_rdata
);

    pli_pkg::t_entry r_mem [pli_pkg::TABLE_DEPTH];
    pli_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pli_div.sv =====
// ============================================================================
// pli_div
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// ============================================================================
module pli_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pli_pkg::t_div_req i_req,
    output pli_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [pli_pkg::QCNT_W-1:0]   r_cnt;
    logic [pli_pkg::E_W-1:0]      r_rem;
    logic [pli_pkg::E_W-1:0]      r_div;
    logic [pli_pkg::XS_W-1:0]     r_q;

    logic [pli_pkg::E_W:0]        w_trial;
    logic [pli_pkg::E_W:0]        w_diff;
    logic                         w_ge;
    logic [pli_pkg::E_W-1:0]      n_rem;

    // trial subtract of the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_q[pli_pkg::XS_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[pli_pkg::E_W-1:0] : w_trial[pli_pkg::E_W-1:0];
    end

    // iteration control; the upper dividend part is always below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.dividend[pli_pkg::PROD_W-1:pli_pkg::XS_W];
                r_q    <= i_req.dividend[pli_pkg::XS_W-1:0];
                r_div  <= i_req.divisor;
                r_cnt  <= pli_pkg::QCNT_W'(pli_pkg::XS_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[pli_pkg::XS_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pli_pkg::QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_q;
    assign o_rsp.rem_nz = |r_rem;

endmodule

// ===== design/pli_ctrl.sv =====
// ============================================================================
// pli_ctrl
// Table sequencer: loads entries, scans for the bracketing pair, interpolates.
// ============================================================================
module pli_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic                        i_opcode,
    input  logic [pli_pkg::ADDR_W-1:0]  i_entry_index,
    input  pli_pkg::t_entry             i_entry,
    input  logic [pli_pkg::CNT_W-1:0]   i_entries_in_use,
    input  logic                        i_hf_present,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output pli_pkg::t_result            o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_DIFF,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic [pli_pkg::E_W-1:0]        r_key;
    logic [pli_pkg::ADDR_W-1:0]     r_last;
    logic [pli_pkg::ADDR_W-1:0]     r_idx;
    pli_pkg::t_entry                r_lo;
    pli_pkg::t_entry                r_hi;
    logic [pli_pkg::E_W-1:0]        r_off;
    logic [pli_pkg::E_W-1:0]        r_span;
    logic [pli_pkg::XS_W-1:0]       r_dxs;
    logic                           r_nxs;
    logic [pli_pkg::HF_W-1:0]       r_dhf;
    logic                           r_nhf;
    logic                           r_pass;
    logic [pli_pkg::PROD_W-1:0]     r_prod;
    pli_pkg::t_result               r_res;

    logic                           w_accept;
    logic                           w_we;
    logic [pli_pkg::ADDR_W-1:0]     w_raddr;
    logic [pli_pkg::ADDR_W-1:0]     n_last;
    pli_pkg::t_entry                w_rdata;
    logic [pli_pkg::XS_W-1:0]       w_dy;
    logic [pli_pkg::PROD_W-1:0]     w_prod;
    logic [pli_pkg::XS_W-1:0]       w_y0;
    logic                           w_neg;
    logic [pli_pkg::XS_W-1:0]       w_y;
    pli_pkg::t_div_req              w_div_req;
    pli_pkg::t_div_rsp              w_div_rsp;

    // input handshake and table writes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_we       = w_accept && (i_opcode == pli_pkg::OP_WRITE);

    // index of the last searched entry, count clamped to two through the table depth
    always_comb begin
        if (i_entries_in_use < pli_pkg::CNT_W'(2)) begin
            n_last = pli_pkg::ADDR_W'(1);
        end else if (i_entries_in_use > pli_pkg::CNT_W'(pli_pkg::TABLE_DEPTH)) begin
            n_last = pli_pkg::ADDR_W'(pli_pkg::TABLE_DEPTH - 1);
        end else begin
            n_last = pli_pkg::ADDR_W'(i_entries_in_use - 1'b1);
        end
    end

    // read address: first entry while idle, then last, then the scan
    always_comb begin
        case (r_state)
            S_CHK_FIRST: w_raddr = r_last;
            S_CHK_LAST:  w_raddr = pli_pkg::ADDR_W'(1);
            S_SCAN:      w_raddr = r_idx + 1'b1;
            default:     w_raddr = '0;
        endcase
    end

    pli_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_entry_index),
        .i_wdata (i_entry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // scaled delta for the current pass
    always_comb begin
        w_dy   = r_pass ? pli_pkg::XS_W'(r_dhf) : r_dxs;
        w_prod = pli_pkg::PROD_W'(w_dy) * pli_pkg::PROD_W'(r_off);
    end

    assign w_div_req.start    = (r_state == S_DIV_GO);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_span;

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // floor of the interpolated value, rounding down on falling segments
    always_comb begin
        w_y0  = r_pass ? pli_pkg::XS_W'(r_lo.hf) : r_lo.xs;
        w_neg = r_pass ? r_nhf : r_nxs;
        if (w_neg) begin
            w_y = w_y0 - w_div_rsp.quot - pli_pkg::XS_W'(w_div_rsp.rem_nz);
        end else begin
            w_y = w_y0 + w_div_rsp.quot;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_opcode == pli_pkg::OP_QUERY)) begin
                        r_key   <= i_entry.energy;
                        r_last  <= n_last;
                        r_state <= S_CHK_FIRST;
                    end
                end
                S_CHK_FIRST: begin
                    r_lo <= w_rdata;
                    if (r_key <= w_rdata.energy) begin
                        r_res   <= {pli_pkg::ST_CLAMP_LO, w_rdata.hf, w_rdata.xs};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST: begin
                    if (r_key >= w_rdata.energy) begin
                        r_res   <= {pli_pkg::ST_CLAMP_HI, w_rdata.hf, w_rdata.xs};
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= pli_pkg::ADDR_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // first entry above the key ends the scan
                    if (w_rdata.energy > r_key) begin
                        r_hi    <= w_rdata;
                        r_state <= S_DIFF;
                    end else begin
                        r_lo  <= w_rdata;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIFF: begin
                    r_off  <= r_key - r_lo.energy;
                    r_span <= r_hi.energy - r_lo.energy;
                    r_nxs  <= (r_hi.xs < r_lo.xs);
                    r_dxs  <= (r_hi.xs < r_lo.xs) ? (r_lo.xs - r_hi.xs)
                                                  : (r_hi.xs - r_lo.xs);
                    r_nhf  <= (r_hi.hf < r_lo.hf);
                    r_dhf  <= (r_hi.hf < r_lo.hf) ? (r_lo.hf - r_hi.hf)
                                                  : (r_hi.hf - r_lo.hf);
                    r_res.clamp <= pli_pkg::ST_INTERP;
                    r_pass  <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        if (!r_pass) begin
                            r_res.xs <= w_y;
                            if (i_hf_present) begin
                                r_pass  <= 1'b1;
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_res.hf <= w_y[pli_pkg::HF_W-1:0];
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result to the output register
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.clamp = r_res.clamp;
    assign o_res.xs    = r_res.xs;
    assign o_res.hf    = i_hf_present ? r_res.hf : pli_pkg::HF_HALF;

    // the scan never runs past the last searched entry
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_last))
        else $error("scan passed the last searched entry");

    // the bracketing pair has positive span containing the key
    a_span_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_off < r_span))
        else $error("interpolation offset not below span");

    // divider answers only while waited on
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider done outside wait state");

    // quotient never exceeds the cross-section delta
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_rsp.done && !r_pass) |-> (w_div_rsp.quot <= r_dxs))
        else $error("quotient above segment delta");

endmodule
